// ----- hw/rtl/itc_pkg.sv -----
// Shared types and constants for the three-channel interval timer.
// Depends on nothing; used by itc_eval and interval_timer_three_channel.
package itc_pkg;

	localparam logic [16:0] FULL_COUNT = 17'h10000;
	localparam logic [47:0] TICK_MAX   = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [1:0] PORT_CTRL = 2'd3;
	localparam logic [1:0] SEL_READBACK = 2'd3;

	// Access kinds and read/write phases.
	localparam logic [2:0] PH_MSB      = 3'd2;
	localparam logic [2:0] PH_WORD_LO  = 3'd3;
	localparam logic [2:0] PH_WORD_HI  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_APPLY = 2'd1,
		ST_EVAL = 2'd2,
		ST_DONE = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic [15:0] count;
		logic        out;
	} eval_t;

endpackage

// ----- hw/rtl/interval_timer_three_channel.sv -----
// Top level of the three-channel interval timer: sequencer, channel state
// and stream ports. Depends on itc_pkg and itc_eval.
//
//  channel   direction  tdata fields (low bit up)            width
//  s_axis    in         action[1:0] port[3:2] wdata[11:4]    16
//  m_axis    out        rdata[7:0] intr[8] out_one[9]        16
//                       out_two[10]
//  cfg       in         cfg_we / cfg_wdata = irq_enable      1
//
// The result of a transaction becomes valid after the edge that accepts it, once
// the sequencer has walked the channels once to apply the item and once more to
// evaluate outputs, all through one shared evaluator, and leaves its final state.
// The next transaction is accepted only when the sequencer is back in idle, so
// items never overlap in the sequencer.
// The remainder of elapsed ticks by the reload value is tracked per channel
// incrementally, so no divider is needed.
// A waiting result sits in the output register; the next item is accepted
// while it waits, and its own result then holds the sequencer in its final
// state until the waiting one leaves. Reset is asynchronous and returns every
// channel to mode 3 with a reload value of 65536.
module interval_timer_three_channel #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // action[1:0], port[3:2], wdata[11:4]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // rdata[7:0], intr[8], out_one[9], out_two[10]
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

	itc_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0] chan_q;

	logic [1:0] action_q;
	logic [1:0] port_q;
	logic [7:0] wdata_q;
	logic [7:0] rdata_q;
	logic       irq_q;
	logic       irq_en_q;
	logic [NUM_CHANNELS-1:0] outs_q;

	logic [16:0] reload_q  [NUM_CHANNELS];
	logic [47:0] elapsed_q [NUM_CHANNELS];
	logic [16:0] rem_q     [NUM_CHANNELS];
	logic [15:0] held_q    [NUM_CHANNELS];
	logic [1:0]  hphase_q  [NUM_CHANNELS];
	logic        sheld_q   [NUM_CHANNELS];
	logic [7:0]  sbyte_q   [NUM_CHANNELS];
	logic [2:0]  rphase_q  [NUM_CHANNELS];
	logic [2:0]  wphase_q  [NUM_CHANNELS];
	logic [7:0]  low_q     [NUM_CHANNELS];
	logic [1:0]  acc_q     [NUM_CHANNELS];
	logic [2:0]  mode_q    [NUM_CHANNELS];
	logic        bcd_q     [NUM_CHANNELS];

	logic        m_valid_q;
	logic [15:0] m_data_q;

	itc_pkg::eval_t ev;

	itc_eval u_eval (
		.reload    (reload_q[chan_q]),
		.elapsed   (elapsed_q[chan_q]),
		.remainder (rem_q[chan_q]),
		.mode      (mode_q[chan_q]),
		.result    (ev)
	);

	logic [1:0] chan_ext;
	logic [1:0] sel;
	logic       rb_hit;
	logic [17:0] rem_inc;

	always_comb begin
		chan_ext = 2'(chan_q);
		sel      = wdata_q[7:6];
		rb_hit   = (wdata_q[3:1] >> chan_q) != 3'd0 ? ((wdata_q[3:1] >> chan_q) & 3'd1) == 3'd1
			: 1'b0;
		rem_inc  = {1'b0, rem_q[chan_q]} + 18'd1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			itc_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = itc_pkg::ST_APPLY;
			itc_pkg::ST_APPLY: if (chan_q == LAST_CH) state_d = itc_pkg::ST_EVAL;
			itc_pkg::ST_EVAL:  if (chan_q == LAST_CH) state_d = itc_pkg::ST_DONE;
			itc_pkg::ST_DONE:  if (!m_valid_q || m_axis_tready) state_d = itc_pkg::ST_IDLE;
			default:           state_d = itc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_axis_tready = (state_q == itc_pkg::ST_IDLE);

	// Sequencer, channel state and result assembly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q    <= '0;
			action_q  <= '0;
			port_q    <= '0;
			wdata_q   <= '0;
			rdata_q   <= '0;
			irq_q     <= 1'b0;
			irq_en_q  <= 1'b1;
			outs_q    <= '0;
			m_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				reload_q[i]  <= itc_pkg::FULL_COUNT;
				elapsed_q[i] <= '0;
				rem_q[i]     <= '0;
				held_q[i]    <= '0;
				hphase_q[i]  <= '0;
				sheld_q[i]   <= 1'b0;
				sbyte_q[i]   <= '0;
				rphase_q[i]  <= '0;
				wphase_q[i]  <= '0;
				low_q[i]     <= '0;
				acc_q[i]     <= '0;
				mode_q[i]    <= 3'd3;
				bcd_q[i]     <= 1'b0;
			end
		end else begin
			if (cfg_we) irq_en_q <= cfg_wdata;
			// A new result replaces the one leaving in the same cycle.
			if (state_q == itc_pkg::ST_DONE && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				itc_pkg::ST_IDLE: begin
					if (s_axis_tvalid) begin
						action_q <= s_axis_tdata[1:0];
						port_q   <= s_axis_tdata[3:2];
						wdata_q  <= s_axis_tdata[11:4];
						rdata_q  <= '0;
						chan_q   <= '0;
					end
				end
				itc_pkg::ST_APPLY: begin
					chan_q <= (chan_q == LAST_CH) ? '0 : chan_q + CW'(1);
					case (action_q)
						itc_pkg::ACT_TICK: begin
							if (elapsed_q[chan_q] != itc_pkg::TICK_MAX) begin
								elapsed_q[chan_q] <= elapsed_q[chan_q] + 48'd1;
								rem_q[chan_q] <= (rem_inc == {1'b0, reload_q[chan_q]}) ? '0
									: rem_inc[16:0];
							end
						end
						itc_pkg::ACT_READ: begin
							if (port_q == chan_ext) begin
								if (sheld_q[chan_q]) begin
									sheld_q[chan_q] <= 1'b0;
									rdata_q <= sbyte_q[chan_q];
								end else if (hphase_q[chan_q] != 2'd0) begin
									case (hphase_q[chan_q])
										2'd2: begin
											hphase_q[chan_q] <= 2'd0;
											rdata_q <= held_q[chan_q][15:8];
										end
										2'd3: begin
											hphase_q[chan_q] <= 2'd2;
											rdata_q <= held_q[chan_q][7:0];
										end
										default: begin
											hphase_q[chan_q] <= 2'd0;
											rdata_q <= held_q[chan_q][7:0];
										end
									endcase
								end else begin
									case (rphase_q[chan_q])
										itc_pkg::PH_MSB: rdata_q <= ev.count[15:8];
										itc_pkg::PH_WORD_LO: begin
											rphase_q[chan_q] <= itc_pkg::PH_WORD_HI;
											rdata_q <= ev.count[7:0];
										end
										itc_pkg::PH_WORD_HI: begin
											rphase_q[chan_q] <= itc_pkg::PH_WORD_LO;
											rdata_q <= ev.count[15:8];
										end
										default: rdata_q <= ev.count[7:0];
									endcase
								end
							end
						end
						itc_pkg::ACT_WRITE: begin
							if (port_q == itc_pkg::PORT_CTRL) begin
								if (sel == itc_pkg::SEL_READBACK) begin
									if (rb_hit) begin
										if (!wdata_q[5] && hphase_q[chan_q] == 2'd0) begin
											held_q[chan_q]   <= ev.count;
											hphase_q[chan_q] <= acc_q[chan_q];
										end
										if (!wdata_q[4] && !sheld_q[chan_q]) begin
											sbyte_q[chan_q] <= {ev.out, 1'b0, acc_q[chan_q],
												mode_q[chan_q], bcd_q[chan_q]};
											sheld_q[chan_q] <= 1'b1;
										end
									end
								end else if (sel == chan_ext) begin
									if (wdata_q[5:4] == 2'd0) begin
										if (hphase_q[chan_q] == 2'd0) begin
											held_q[chan_q]   <= ev.count;
											hphase_q[chan_q] <= acc_q[chan_q];
										end
									end else begin
										acc_q[chan_q]    <= wdata_q[5:4];
										rphase_q[chan_q] <= {1'b0, wdata_q[5:4]};
										wphase_q[chan_q] <= {1'b0, wdata_q[5:4]};
										mode_q[chan_q]   <= wdata_q[3:1];
										bcd_q[chan_q]    <= wdata_q[0];
									end
								end
							end else if (port_q == chan_ext) begin
								case (wphase_q[chan_q])
									itc_pkg::PH_WORD_LO: begin
										low_q[chan_q]    <= wdata_q;
										wphase_q[chan_q] <= itc_pkg::PH_WORD_HI;
									end
									itc_pkg::PH_MSB: begin
										reload_q[chan_q]  <= {1'b0, wdata_q, 8'h00} == '0
											? itc_pkg::FULL_COUNT : {1'b0, wdata_q, 8'h00};
										elapsed_q[chan_q] <= '0;
										rem_q[chan_q]     <= '0;
									end
									itc_pkg::PH_WORD_HI: begin
										reload_q[chan_q] <= {wdata_q, low_q[chan_q]} == '0
											? itc_pkg::FULL_COUNT : {1'b0, wdata_q, low_q[chan_q]};
										elapsed_q[chan_q] <= '0;
										rem_q[chan_q]     <= '0;
										wphase_q[chan_q]  <= itc_pkg::PH_WORD_LO;
									end
									default: begin
										reload_q[chan_q]  <= wdata_q == '0
											? itc_pkg::FULL_COUNT : {9'd0, wdata_q};
										elapsed_q[chan_q] <= '0;
										rem_q[chan_q]     <= '0;
									end
								endcase
							end
						end
						default: ;
					endcase
				end
				itc_pkg::ST_EVAL: begin
					chan_q <= (chan_q == LAST_CH) ? '0 : chan_q + CW'(1);
					outs_q[chan_q] <= ev.out;
					if (chan_q == '0 && irq_en_q) irq_q <= ev.out;
				end
				default: ;
			endcase
		end
	end

	// Payload of the result register needs no reset.
	logic out_one_w;
	logic out_two_w;

	always_comb begin
		out_one_w = 1'b0;
		out_two_w = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (i == 1) out_one_w = outs_q[i];
			if (i == 2) out_two_w = outs_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == itc_pkg::ST_DONE && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {5'd0, out_two_w, out_one_w, irq_q, rdata_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// The tracked remainder always stays below the reload value.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q[0] < reload_q[0])
		else $error("channel 0 remainder not below reload value");

	// A fresh load or reset leaves a zero remainder.
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q[0] == '0 |-> rem_q[0] == '0)
		else $error("remainder nonzero with no elapsed ticks");

	// An accepted transaction holds off the next one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// A result is only raised from the final sequencer state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == itc_pkg::ST_DONE)
		else $error("result raised outside final state");

endmodule

// ----- hw/rtl/itc_eval.sv -----
// Shared count and output evaluator for one timer channel at a time.
// Depends on itc_pkg.
module itc_eval (
	input  logic [16:0]   reload,
	input  logic [47:0]   elapsed,
	input  logic [16:0]   remainder,
	input  logic [2:0]    mode,
	output itc_pkg::eval_t result
);

	logic [2:0]  eff_mode;
	logic [17:0] twice_rem;
	logic [16:0] rem_twice;
	logic [17:0] half_up;
	logic        d_below_n;
	logic        d_equal_n;
	logic [16:0] diff;

	always_comb begin
		eff_mode  = (mode >= 3'd6) ? (mode - 3'd4) : mode;
		twice_rem = {remainder, 1'b0};
		rem_twice = (twice_rem >= {1'b0, reload}) ? 17'(twice_rem - {1'b0, reload})
			: twice_rem[16:0];
		half_up   = ({1'b0, reload} + 18'd1) >> 1;
		d_below_n = (elapsed[47:17] == '0) && (elapsed[16:0] < reload);
		d_equal_n = (elapsed[47:17] == '0) && (elapsed[16:0] == reload);
		diff      = 17'(reload - {1'b0, elapsed[15:0]});
		case (eff_mode)
			3'd2: begin
				result.count = 16'(reload - remainder);
				result.out   = (remainder == '0) && (elapsed != '0);
			end
			3'd3: begin
				result.count = 16'(reload - rem_twice);
				result.out   = {1'b0, remainder} < half_up;
			end
			3'd1: begin
				result.count = diff[15:0];
				result.out   = d_below_n;
			end
			3'd4, 3'd5: begin
				result.count = diff[15:0];
				result.out   = d_equal_n;
			end
			default: begin
				result.count = diff[15:0];
				result.out   = !d_below_n;
			end
		endcase
	end

endmodule

// ----- test/interval_timer_three_channel_tb.sv -----
// Testbench for the three-channel interval timer: directed and random stream
// traffic, checked against a scoreboard that models every channel in software.
// Depends on itc_pkg and the interval_timer_three_channel RTL.
`timescale 1ns / 100ps

module interval_timer_three_channel_tb;

	localparam int          NCH        = 3;
	localparam int          LATENCY    = 2 * NCH + 2;
	localparam int          CYCLE_LIMIT = 600000;
	localparam int          RANDOM_ITEMS = 1250;
	localparam logic [1:0]  ACC_LATCH  = 2'd0;
	localparam logic [1:0]  ACC_MSB    = 2'd2;
	localparam logic [1:0]  ACC_WORD   = 2'd3;
	localparam logic [7:0]  CW_NO_COUNT  = 8'h20;
	localparam logic [7:0]  CW_NO_STATUS = 8'h10;

	// Software copy of the timer. note_input() applies one accepted transaction
	// and queues the result it must produce; check_result() compares a result.
	class timer_scoreboard;
		logic [16:0] reload[NCH];
		logic [47:0] elapsed[NCH];
		logic [15:0] held[NCH];
		logic [1:0]  held_ph[NCH];
		bit          st_held[NCH];
		logic [7:0]  st_byte[NCH];
		logic [2:0]  rph[NCH];
		logic [2:0]  wph[NCH];
		logic [7:0]  lo_hold[NCH];
		logic [1:0]  acc[NCH];
		logic [2:0]  mode[NCH];
		bit          bcd[NCH];
		bit          irq;
		bit          irq_en;
		logic [15:0] expected_results[$];
		int          errors;

		function new();
			for (int c = 0; c < NCH; c++) begin
				reload[c] = itc_pkg::FULL_COUNT;
				elapsed[c] = '0;
				held[c] = '0;
				held_ph[c] = '0;
				st_held[c] = 0;
				st_byte[c] = '0;
				rph[c] = '0;
				wph[c] = '0;
				lo_hold[c] = '0;
				acc[c] = '0;
				mode[c] = 3'd3;
				bcd[c] = 0;
			end
			irq = 0;
			irq_en = 1;
			errors = 0;
		endfunction

		function int eff_mode(int c);
			return (mode[c] >= 6) ? mode[c] - 4 : mode[c];
		endfunction

		function logic [15:0] count_now(int c);
			longint unsigned n, d;
			n = (reload[c] == 0) ? 64'h10000 : reload[c];
			d = elapsed[c];
			case (eff_mode(c))
				2: return 16'(n - (d % n));
				3: return 16'(n - ((2 * d) % n));
				default: return 16'(n - d);
			endcase
		endfunction

		function bit out_now(int c);
			longint unsigned n, d;
			n = (reload[c] == 0) ? 64'h10000 : reload[c];
			d = elapsed[c];
			case (eff_mode(c))
				1: return d < n;
				2: return (d % n) == 0 && d != 0;
				3: return (d % n) < ((n + 1) >> 1);
				4, 5: return d == n;
				default: return d >= n;
			endcase
		endfunction

		function void load(int c, logic [16:0] v);
			reload[c] = (v == 0) ? itc_pkg::FULL_COUNT : v;
			elapsed[c] = '0;
		endfunction

		function void latch(int c);
			if (held_ph[c] == 0) begin
				held[c] = count_now(c);
				held_ph[c] = acc[c];
			end
		endfunction

		function void control(logic [7:0] v);
			int sel;
			sel = v[7:6];
			if (sel == itc_pkg::SEL_READBACK) begin
				for (int c = 0; c < NCH; c++) begin
					if (!v[c + 1])
						continue;
					if (!(v & CW_NO_COUNT))
						latch(c);
					if (!(v & CW_NO_STATUS) && !st_held[c]) begin
						st_byte[c] = {out_now(c), 1'b0, acc[c], mode[c], bcd[c]};
						st_held[c] = 1;
					end
				end
			end else if (v[5:4] == ACC_LATCH) begin
				latch(sel);
			end else begin
				acc[sel] = v[5:4];
				rph[sel] = {1'b0, v[5:4]};
				wph[sel] = {1'b0, v[5:4]};
				mode[sel] = v[3:1];
				bcd[sel] = v[0];
			end
		endfunction

		function void data_write(int c, logic [7:0] v);
			case (wph[c])
				itc_pkg::PH_MSB: load(c, {1'b0, v, 8'h00});
				itc_pkg::PH_WORD_LO: begin
					lo_hold[c] = v;
					wph[c] = itc_pkg::PH_WORD_HI;
				end
				itc_pkg::PH_WORD_HI: begin
					load(c, {1'b0, v, lo_hold[c]});
					wph[c] = itc_pkg::PH_WORD_LO;
				end
				default: load(c, {9'b0, v});
			endcase
		endfunction

		function logic [7:0] data_read(int c);
			logic [15:0] cnt;
			if (st_held[c]) begin
				st_held[c] = 0;
				return st_byte[c];
			end
			if (held_ph[c] != 0) begin
				if (held_ph[c] == ACC_MSB) begin
					held_ph[c] = 0;
					return held[c][15:8];
				end else if (held_ph[c] == ACC_WORD) begin
					held_ph[c] = ACC_MSB;
					return held[c][7:0];
				end
				held_ph[c] = 0;
				return held[c][7:0];
			end
			cnt = count_now(c);
			case (rph[c])
				itc_pkg::PH_MSB: return cnt[15:8];
				itc_pkg::PH_WORD_LO: begin
					rph[c] = itc_pkg::PH_WORD_HI;
					return cnt[7:0];
				end
				itc_pkg::PH_WORD_HI: begin
					rph[c] = itc_pkg::PH_WORD_LO;
					return cnt[15:8];
				end
				default: return cnt[7:0];
			endcase
		endfunction

		function void note_input(logic [15:0] tdata);
			itc_pkg::action_t act;
			logic [1:0]  prt;
			logic [7:0]  wd;
			logic [7:0]  rd;
			act = itc_pkg::action_t'(tdata[1:0]);
			prt = tdata[3:2];
			wd = tdata[11:4];
			rd = '0;
			case (act)
				itc_pkg::ACT_TICK:
					for (int c = 0; c < NCH; c++)
						if (elapsed[c] != itc_pkg::TICK_MAX)
							elapsed[c]++;
				itc_pkg::ACT_READ:
					if (prt != itc_pkg::PORT_CTRL)
						rd = data_read(prt);
				itc_pkg::ACT_WRITE:
					if (prt == itc_pkg::PORT_CTRL)
						control(wd);
					else
						data_write(prt, wd);
				default: ;
			endcase
			if (irq_en)
				irq = out_now(0);
			expected_results.push_back({5'b0, out_now(2), out_now(1), irq, rd});
		endfunction

		function void check_result(logic [15:0] got);
			logic [15:0] exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: result %h with none expected", $time, got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got[7:0] !== exp_r[7:0]) begin
				$display("%0t: rdata expected %h actual %h", $time, exp_r[7:0], got[7:0]);
				errors++;
			end
			if (got[8] !== exp_r[8]) begin
				$display("%0t: interrupt expected %b actual %b", $time, exp_r[8], got[8]);
				errors++;
			end
			if (got[9] !== exp_r[9]) begin
				$display("%0t: out_one expected %b actual %b", $time, exp_r[9], got[9]);
				errors++;
			end
			if (got[10] !== exp_r[10]) begin
				$display("%0t: out_two expected %b actual %b", $time, exp_r[10], got[10]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 0;
	logic        cfg_wdata = 0;

	timer_scoreboard sb = new();
	bit  idle_on = 1;      // random bursts of idling on both sides
	bit  hold_req = 0;     // asks the receiver for one long hold-off
	int  cycles = 0;
	int  items_sent = 0;

	interval_timer_three_channel #(.NUM_CHANNELS(NCH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Every accepted result goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// block fills its output register and pushes back on the input side.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 0;
				for (n = 0; n < 400; n++)
					@(negedge clk);
				hold_req = 0;
				m_axis_tready = 1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready = 0;
				n = $urandom_range(1, 18);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1;
			end
		end
	end

	// Offers one transaction and returns after the edge that accepts it.
	// The valid stays high so back-to-back transactions need no gap.
	task automatic send_item(itc_pkg::action_t act, logic [1:0] prt, logic [7:0] wd);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid = 0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {4'b0, wd, prt, act};
		s_axis_tvalid = 1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(s_axis_tdata);
		items_sent++;
		@(negedge clk);
	endtask

	// Waits until every expected result has arrived, then lets the pipeline
	// settle before the interrupt enable may change.
	task automatic drain();
		s_axis_tvalid = 0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (LATENCY * 3) @(negedge clk);
	endtask

	task automatic set_irq_enable(bit v);
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
		sb.irq_en = v;
	endtask

	// Programs a channel: control word, then one or two reload bytes chosen
	// small most of the time so the outputs toggle often.
	task automatic program_channel(int ch);
		logic [1:0] a;
		logic [7:0] lo;
		a = 2'($urandom_range(1, 3));
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, {2'(ch), a,
			3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))});
		lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
		if (a == ACC_WORD) begin
			send_item(itc_pkg::ACT_WRITE, 2'(ch), lo);
			send_item(itc_pkg::ACT_WRITE, 2'(ch),
				($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
		end else if (a == ACC_MSB) begin
			send_item(itc_pkg::ACT_WRITE, 2'(ch),
				($urandom_range(0, 1)) ? 8'h00 : 8'($urandom));
		end else begin
			send_item(itc_pkg::ACT_WRITE, 2'(ch), lo);
		end
	endtask

	task automatic random_traffic(int count);
		int k, sel, ch, n;
		k = items_sent + count;
		while (items_sent < k) begin
			sel = $urandom_range(0, 99);
			ch = $urandom_range(0, NCH - 1);
			if (sel < 25) begin
				program_channel(ch);
			end else if (sel < 55) begin
				n = $urandom_range(1, 25);
				repeat (n) send_item(itc_pkg::ACT_TICK, 2'($urandom), 8'($urandom));
			end else if (sel < 70) begin
				repeat ($urandom_range(1, 2))
					send_item(itc_pkg::ACT_READ, 2'(ch), 8'($urandom));
			end else if (sel < 80) begin
				send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL,
					{2'(ch), ACC_LATCH, 4'($urandom)});
				repeat ($urandom_range(1, 3))
					send_item(itc_pkg::ACT_READ, 2'(ch), 8'($urandom));
			end else if (sel < 90) begin
				send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL,
					{itc_pkg::SEL_READBACK, 6'($urandom)});
				repeat ($urandom_range(1, 3))
					send_item(itc_pkg::ACT_READ, 2'(ch), 8'($urandom));
			end else begin
				send_item(itc_pkg::action_t'($urandom_range(0, 3)), 2'($urandom),
					8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		set_irq_enable(1);

		// Directed part: modes 0, 2, 3 and 5, each access kind, zero reload, latches,
		// read-back, status, the aliased modes six and seven, the undefined
		// action and a read of the control port.
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'h10);  // ch0 mode 0, LSB
		send_item(itc_pkg::ACT_WRITE, 2'd0, 8'h05);
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'h74);  // ch1 mode 2, word
		send_item(itc_pkg::ACT_WRITE, 2'd1, 8'h03);
		send_item(itc_pkg::ACT_WRITE, 2'd1, 8'h00);
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'hA6);  // ch2 mode 3, MSB
		send_item(itc_pkg::ACT_WRITE, 2'd2, 8'h00);                // zero reload
		repeat (6) send_item(itc_pkg::ACT_TICK, 2'd0, 8'h00);
		send_item(itc_pkg::ACT_READ, 2'd0, 8'h00);
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'h40);  // ch1 count latch
		send_item(itc_pkg::ACT_READ, 2'd1, 8'h00);
		send_item(itc_pkg::ACT_READ, 2'd1, 8'h00);
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'hCE);  // read-back all
		send_item(itc_pkg::ACT_READ, 2'd0, 8'h00);
		send_item(itc_pkg::ACT_READ, 2'd2, 8'h00);
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'h1E);  // ch0 mode 7
		send_item(itc_pkg::ACT_WRITE, 2'd0, 8'hFF);
		send_item(itc_pkg::ACT_NONE, 2'd3, 8'hFF);
		send_item(itc_pkg::ACT_READ, itc_pkg::PORT_CTRL, 8'h00);
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'h1C);  // ch0 mode 6
		send_item(itc_pkg::ACT_WRITE, itc_pkg::PORT_CTRL, 8'h5A);  // ch1 mode 5, LSB
		drain();

		set_irq_enable(0);
		random_traffic(RANDOM_ITEMS / 4);
		hold_req = 1;
		random_traffic(RANDOM_ITEMS / 4);
		drain();
		set_irq_enable(1);
		random_traffic(RANDOM_ITEMS / 4);
		drain();
		set_irq_enable(0);
		random_traffic(RANDOM_ITEMS / 8);
		drain();

		// Last part runs with both sides streaming continuously.
		set_irq_enable(1);
		idle_on = 0;
		random_traffic(RANDOM_ITEMS / 8);
		drain();

		if (sb.errors == 0 && sb.expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
